FILE: rtl/core/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared widths and codes for the prime sieve table.
// ----------------------------------------------------------------------------
package pst_pkg;

	localparam int QUERY_W  = 16;
	localparam int LIMIT_W  = 17;
	localparam int STATUS_W = 2;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_RANGE     = 2'd1;
	localparam status_t STATUS_NOT_BUILT = 2'd2;

	localparam logic REQ_BUILD = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

endpackage

FILE: rtl/core/prime_sieve_table.sv
// ----------------------------------------------------------------------------
// prime_sieve_table
// Sieve of Eratosthenes engine over a one-bit primality table held in RAM.
// ----------------------------------------------------------------------------
// query: table read stage, then output register; one query accepted per cycle
//   while idle and the output is not stalled
// rebuild: fill of entries below L (one entry per cycle, L = saturated limit), then
//   per candidate i with i*i < L a table read, for a prime i marking of multiples
//   from i*i below L, then scan end and result post; ready stays low meanwhile
// reset: control cleared, table contents undefined; queries before the first
//   rebuild report not built, no clearing pass is run
module prime_sieve_table #(
	parameter int TABLE_SIZE = 65536
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [pst_pkg::LIMIT_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic [pst_pkg::QUERY_W-1:0] query_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        is_prime,
	output pst_pkg::status_t            status
);

	import pst_pkg::*;

	localparam int AW   = $clog2(TABLE_SIZE);
	localparam int LW   = $clog2(TABLE_SIZE + 1);
	localparam int CW   = LW + 1;
	localparam int SW   = (LW > LIMIT_W) ? LW : LIMIT_W;
	localparam int QCW  = (LW > QUERY_W) ? LW : QUERY_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FILL = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_TEST = 3'd3;
	localparam logic [2:0] S_MARK = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [LIMIT_W-1:0] sieve_limit_q;
	logic [2:0]         state_q;
	logic [LW-1:0]      lim_q;
	logic [LW-1:0]      built_lim_q;
	logic               built_q;
	logic [CW-1:0]      cnt_q;
	logic [LW-1:0]      i_q;
	logic [CW-1:0]      sq_q;

	logic               vld_s1;
	status_t            stat_s1;
	logic               mem_s1;
	logic               out_valid_q;
	logic               is_prime_q;
	status_t            status_q;

	logic [LW-1:0]      lim_sat;
	logic               s1_adv;
	logic               acc;
	logic               acc_query;
	logic               acc_build;
	logic               cnt_below;
	logic               sq_below;
	logic               done_go;
	logic               q_range;
	logic [CW-1:0]      sq_next;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic               ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic               ram_rdata;

	assign lim_sat   = (SW'(sieve_limit_q) > SW'(TABLE_SIZE)) ? LW'(TABLE_SIZE)
	                                                          : LW'(sieve_limit_q);
	assign s1_adv    = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && (!vld_s1 || s1_adv);
	assign acc       = in_valid && in_ready;
	assign acc_query = acc && (req_type == REQ_QUERY);
	assign acc_build = acc && (req_type == REQ_BUILD);
	assign cnt_below = cnt_q < CW'(lim_q);
	assign sq_below  = sq_q < CW'(lim_q);
	assign done_go   = (state_q == S_DONE) && (!vld_s1 || s1_adv);
	assign q_range   = QCW'(query_value) >= QCW'(built_lim_q);
	assign sq_next   = sq_q + {i_q, 1'b1};

	assign ram_we    = ((state_q == S_FILL) || (state_q == S_MARK)) && cnt_below;
	assign ram_waddr = cnt_q[AW-1:0];
	assign ram_wdata = (state_q == S_FILL) && (cnt_q >= CW'(2));
	assign ram_re    = acc_query || ((state_q == S_RD) && sq_below);
	assign ram_raddr = acc_query ? AW'(query_value) : i_q[AW-1:0];

	pst_ram #(
		.WIDTH(1),
		.DEPTH(TABLE_SIZE)
	) u_marks (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sieve_limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			sieve_limit_q <= cfg_wr_data;
		end
	end

	// sieve sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			built_q     <= 1'b0;
			built_lim_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc_build) begin
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (!cnt_below) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= sq_below ? S_TEST : S_DONE;
				end
				S_TEST: begin
					state_q <= ram_rdata ? S_MARK : S_RD;
				end
				S_MARK: begin
					if (!cnt_below) begin
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (done_go) begin
						state_q     <= S_IDLE;
						built_q     <= 1'b1;
						built_lim_q <= lim_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				lim_q <= lim_sat;
				cnt_q <= '0;
				i_q   <= LW'(2);
				sq_q  <= CW'(4);
			end
			S_FILL: begin
				if (cnt_below) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			S_TEST: begin
				cnt_q <= sq_q;
				if (!ram_rdata) begin
					i_q  <= i_q + LW'(1);
					sq_q <= sq_next;
				end
			end
			S_MARK: begin
				if (cnt_below) begin
					cnt_q <= cnt_q + CW'(i_q);
				end else begin
					i_q  <= i_q + LW'(1);
					sq_q <= sq_next;
				end
			end
			default: begin
			end
		endcase
	end

	// read stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc_query || done_go) begin
				vld_s1 <= 1'b1;
			end else if (s1_adv) begin
				vld_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_query) begin
			priority if (!built_q) begin
				stat_s1 <= STATUS_NOT_BUILT;
				mem_s1  <= 1'b0;
			end else if (q_range) begin
				stat_s1 <= STATUS_RANGE;
				mem_s1  <= 1'b0;
			end else begin
				stat_s1 <= STATUS_OK;
				mem_s1  <= 1'b1;
			end
		end else if (done_go) begin
			stat_s1 <= STATUS_OK;
			mem_s1  <= 1'b0;
		end
		if (s1_adv) begin
			is_prime_q <= mem_s1 & ram_rdata;
			status_q   <= stat_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;
	assign status    = status_q;

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("input accepted during rebuild");

	a_write_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (cnt_q < CW'(lim_q)))
		else $error("table write beyond build limit");

	a_prime_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_prime) |-> (status == STATUS_OK))
		else $error("prime reported with error status");

	a_build_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done_go |=> built_q)
		else $error("build finished without setting built flag");

endmodule

FILE: rtl/core/pst_ram.sv
// ----------------------------------------------------------------------------
// pst_ram
// Generic single-clock RAM, one write port and one read port with a
// registered read that holds its data when the read is not enabled.
// ----------------------------------------------------------------------------
module pst_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
